@@ hdl/box_downscale_2x2_4x4_top_defines.svh @@
//------------------------------------------------------------------------------
// Box downscaler assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
//------------------------------------------------------------------------------
`ifndef BOX_DOWNSCALE_2X2_4X4_TOP_DEFINES_SVH
`define BOX_DOWNSCALE_2X2_4X4_TOP_DEFINES_SVH

// condition must never hold at a clock edge
`define BDS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bds_pkg.sv @@
//------------------------------------------------------------------------------
// Box downscaler package
// Widths, register indexes, mode codes and stage types shared by the block.
//------------------------------------------------------------------------------
package bds_pkg;

   localparam int PIX_W         = 8;
   localparam int DIM_W         = 12;
   localparam int CNT_W         = 11;
   localparam int SUM_W         = 12;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 12;
   localparam int HEIGHT_LIMIT  = 2048;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int OUTQ_DEPTH    = 3;

   localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALT_FRAMES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;

   // scale_mode codes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_AVG2 = 2'd1;
   localparam logic [1:0] MODE_AVG4 = 2'd2;

   // factor of the current frame
   localparam logic [1:0] FACT_NONE = 2'd0;
   localparam logic [1:0] FACT_2    = 2'd1;
   localparam logic [1:0] FACT_4    = 2'd2;

   typedef struct packed {
      logic             go;
      logic             pass;
      logic             access;
      logic             emit;
      logic             first_row;
      logic             shift4;
      logic [CNT_W-1:0] col_idx;
      logic [SUM_W-1:0] row_sum;
      logic [PIX_W-1:0] pixel;
      logic             last;
   } step_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_pixel;
      logic             frame_done;
      logic             was_scaled;
   } out_item_type;

endpackage

@@ hdl/bds_ctrl.sv @@
//------------------------------------------------------------------------------
// Box downscaler control stage
// Config registers, frame setup, raster counters and the running row sum.
//------------------------------------------------------------------------------
module bds_ctrl import bds_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  accept,
   input  logic [PIX_W-1:0]      pixel,
   output step_type              step
);

`include "box_downscale_2x2_4x4_top_defines.svh"

   logic [1:0]       scale_mode_ff, scale_mode_in;
   logic             alt_frames_ff, alt_frames_in;
   logic [DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [DIM_W-1:0] frame_height_ff, frame_height_in;

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] cur_w_ff, cur_w_in;
   logic [DIM_W-1:0] cur_h_ff, cur_h_in;
   logic [1:0]       cur_f_ff, cur_f_in;
   logic             scaled_last_ff, scaled_last_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;

   logic             start, sel, div_ok, scaled;
   logic [1:0]       cand_f, eff_f;
   logic [DIM_W-1:0] w_c, h_c, eff_w, eff_h;
   logic [CNT_W-1:0] mask;
   logic             col_end, row_first, row_end, last_col, last_row;
   logic [CNT_W+1:0] col_inc, row_inc;
   logic [SUM_W-1:0] rs_base, rs_new;

   // config writes
   always_comb begin
      scale_mode_in   = scale_mode_ff;
      alt_frames_in   = alt_frames_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_SCALE_MODE:   scale_mode_in   = csr_wdata[1:0];
            REG_ALT_FRAMES:   alt_frames_in   = csr_wdata[0];
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // frame setup, valid only on the first pixel of a frame
   always_comb begin
      start = (col_ff == '0) && (row_ff == '0);
      sel   = (scale_mode_ff != MODE_NONE) && (!alt_frames_ff || !scaled_last_ff);
      if (frame_width_ff == '0)
         w_c = DIM_W'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH)
         w_c = DIM_W'(MAX_WIDTH);
      else
         w_c = frame_width_ff;
      if (frame_height_ff == '0)
         h_c = DIM_W'(1);
      else if (32'(frame_height_ff) > HEIGHT_LIMIT)
         h_c = DIM_W'(HEIGHT_LIMIT);
      else
         h_c = frame_height_ff;
      if (sel && scale_mode_ff == MODE_AVG2)
         cand_f = FACT_2;
      else if (sel && scale_mode_ff == MODE_AVG4)
         cand_f = FACT_4;
      else
         cand_f = FACT_NONE;
      case (cand_f)
         FACT_2:  div_ok = !w_c[0] && !h_c[0];
         FACT_4:  div_ok = (w_c[1:0] == 2'b00) && (h_c[1:0] == 2'b00);
         default: div_ok = 1'b0;
      endcase
      eff_w   = start ? w_c : cur_w_ff;
      eff_h   = start ? h_c : cur_h_ff;
      eff_f   = start ? (div_ok ? cand_f : FACT_NONE) : cur_f_ff;
      rs_base = start ? '0 : row_sum_ff;
   end

   // position within the block and the frame
   always_comb begin
      scaled    = (eff_f != FACT_NONE);
      mask      = (eff_f == FACT_4) ? CNT_W'(3) : CNT_W'(1);
      col_end   = (col_ff & mask) == mask;
      row_first = (row_ff & mask) == '0;
      row_end   = (row_ff & mask) == mask;
      col_inc   = {2'b00, col_ff} + (CNT_W+2)'(1);
      row_inc   = {2'b00, row_ff} + (CNT_W+2)'(1);
      last_col  = col_inc >= (CNT_W+2)'(eff_w);
      last_row  = row_inc >= (CNT_W+2)'(eff_h);
      rs_new    = rs_base + SUM_W'(pixel);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_inc[CNT_W-1:0];
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
      end

      cur_w_in       = (accept && start) ? w_c : cur_w_ff;
      cur_h_in       = (accept && start) ? h_c : cur_h_ff;
      cur_f_in       = (accept && start) ? eff_f : cur_f_ff;
      scaled_last_in = (accept && start) ? sel : scaled_last_ff;

      row_sum_in = row_sum_ff;
      if (accept) begin
         if (!scaled)
            row_sum_in = rs_base;
         else if (col_end)
            row_sum_in = '0;
         else
            row_sum_in = rs_new;
      end
   end

   always_comb begin
      step.go        = accept;
      step.pass      = !scaled;
      step.access    = scaled && col_end;
      step.emit      = row_end;
      step.first_row = row_first;
      step.shift4    = (eff_f == FACT_4);
      step.col_idx   = (eff_f == FACT_4) ? (col_ff >> 2) : (col_ff >> 1);
      step.row_sum   = rs_new;
      step.pixel     = pixel;
      step.last      = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff   <= MODE_NONE;
         alt_frames_ff   <= 1'b0;
         frame_width_ff  <= RST_WIDTH;
         frame_height_ff <= RST_HEIGHT;
         col_ff          <= '0;
         row_ff          <= '0;
         cur_w_ff        <= '0;
         cur_h_ff        <= '0;
         cur_f_ff        <= FACT_NONE;
         scaled_last_ff  <= 1'b0;
         row_sum_ff      <= '0;
      end else begin
         scale_mode_ff   <= scale_mode_in;
         alt_frames_ff   <= alt_frames_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         cur_w_ff        <= cur_w_in;
         cur_h_ff        <= cur_h_in;
         cur_f_ff        <= cur_f_in;
         scaled_last_ff  <= scaled_last_in;
         row_sum_ff      <= row_sum_in;
      end
   end

   `BDS_ASSERT_NEXT(a_wrap_on_last, accept && step.last, (col_ff == '0) && (row_ff == '0), "counters did not wrap after the last pixel of a frame")

endmodule

@@ hdl/bds_colsum.sv @@
//------------------------------------------------------------------------------
// Box downscaler column sum memory
// Holds partial block sums per output column; read, accumulate, write back.
//------------------------------------------------------------------------------
module bds_colsum import bds_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  step_type     step,
   output logic         res_valid,
   output out_item_type res_item
);

`include "box_downscale_2x2_4x4_top_defines.svh"

   localparam int COLS = MAX_WIDTH / 2;
   localparam int AW   = $clog2(COLS);

   logic [SUM_W-1:0] col_mem [COLS];
   logic [SUM_W-1:0] rdata_ff;
   step_type         s1_ff, s1_in;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [SUM_W-1:0] total;

   // the first block row starts from zero, so it never needs a read
   assign rd_en   = step.go && step.access && !step.first_row;
   assign rd_addr = AW'(step.col_idx);
   assign wr_addr = AW'(s1_ff.col_idx);
   assign s1_in   = step;

   always_comb begin
      total = (s1_ff.first_row ? '0 : rdata_ff) + s1_ff.row_sum;
      wr_en = s1_ff.go && s1_ff.access && !s1_ff.emit;
      res_valid = s1_ff.go && (s1_ff.pass || (s1_ff.access && s1_ff.emit));
      res_item.frame_done = s1_ff.last;
      res_item.was_scaled = !s1_ff.pass;
      if (s1_ff.pass)
         res_item.out_pixel = s1_ff.pixel;
      else if (s1_ff.shift4)
         res_item.out_pixel = total[SUM_W-1:4];
      else
         res_item.out_pixel = total[PIX_W+1:2];
   end

   always_ff @(posedge clock) begin
      if (rd_en)
         rdata_ff <= col_mem[rd_addr];
      if (wr_en)
         col_mem[wr_addr] <= total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.go <= 1'b0;
      end else begin
         s1_ff.go <= s1_in.go;
      end
      s1_ff.pass      <= s1_in.pass;
      s1_ff.access    <= s1_in.access;
      s1_ff.emit      <= s1_in.emit;
      s1_ff.first_row <= s1_in.first_row;
      s1_ff.shift4    <= s1_in.shift4;
      s1_ff.col_idx   <= s1_in.col_idx;
      s1_ff.row_sum   <= s1_in.row_sum;
      s1_ff.pixel     <= s1_in.pixel;
      s1_ff.last      <= s1_in.last;
   end

   // accesses to one column are at least a block width apart, so no forwarding
   `BDS_ASSERT_NEVER(a_no_rw_collision, rd_en && wr_en && (rd_addr == wr_addr), "column sum read and write hit the same entry")
   `BDS_ASSERT_NEVER(a_pass_no_access, s1_ff.go && s1_ff.pass && s1_ff.access, "pass-through pixel touched the column sums")

endmodule

@@ hdl/bds_outq.sv @@
//------------------------------------------------------------------------------
// Box downscaler output queue
// Three-entry queue that decouples the result channel from the pipeline.
//------------------------------------------------------------------------------
module bds_outq import bds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  out_item_type push_item,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output out_item_type head_item,
   output logic [1:0]   count
);

`include "box_downscale_2x2_4x4_top_defines.svh"

   out_item_type q_ff [OUTQ_DEPTH];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head_item = q_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == 2'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 2'd1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == 2'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 2'd1;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         q_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BDS_ASSERT_NEVER(a_no_overflow, push && !pop && (count_ff == 2'(OUTQ_DEPTH)), "push into a full output queue")
   `BDS_ASSERT_NEVER(a_count_range, count_ff > 2'(OUTQ_DEPTH), "output queue count out of range")

endmodule

@@ hdl/box_downscale_2x2_4x4_top.sv @@
//------------------------------------------------------------------------------
// Box downscaler top level
// 2x2 / 4x4 box-filter downscaler for an 8-bit grayscale raster stream.
//------------------------------------------------------------------------------
// Pixels enter on req_ in raster order; each transaction moves one pixel.
// Results leave on rsp_: one per input pixel in pass-through frames, one per
// block (on its bottom-right pixel) in scaled frames, with frame_done on the
// last result of a frame. The csr_ port writes scale mode, alternation and
// frame size; values are sampled on the first pixel of each frame.
// A result passes through the accumulate stage register and the output queue before it is offered on rsp_.
// Throughput: one pixel per cycle while req_stall is low, set by the single read
// and single write port of the column sum memory, each used at most once per pixel
// in a two-stage read-accumulate-write loop, plus a three-entry output queue.
// When the receiver stalls, results collect in the queue and req_stall rises
// once the queue and the accumulate stage could not absorb another result.
// Reset clears the counters and queue and returns the config registers to their
// defaults; the column sum memory needs no clearing pass, since every block's first row starts from zero.
//------------------------------------------------------------------------------
module box_downscale_2x2_4x4_top import bds_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIX_W-1:0]      req_in_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_out_pixel,
   output logic                  rsp_frame_done,
   output logic                  rsp_was_scaled,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   step_type     step;
   logic         accept;
   logic         res_valid;
   out_item_type res_item;
   out_item_type head_item;
   logic [1:0]   q_count;

   // hold input while the queue plus the accumulate stage could fill it
   assign req_stall = (3'(q_count) + 3'(res_valid)) >= 3'(OUTQ_DEPTH);
   assign accept    = req_valid && !req_stall;

   bds_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .pixel        (req_in_pixel),
      .step         (step)
   );

   bds_colsum #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_colsum (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   bds_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head_item (head_item),
      .count     (q_count)
   );

   assign rsp_out_pixel  = head_item.out_pixel;
   assign rsp_frame_done = head_item.frame_done;
   assign rsp_was_scaled = head_item.was_scaled;

endmodule

@@ bench/tb_top.sv @@
//------------------------------------------------------------------------------
// Box downscaler testbench
// Streams raster frames through the 2x2 / 4x4 box downscaler under changing
// mode, alternation and frame size settings, with idle and stall patterns on
// both channels, and checks every result against a behavioral model of the
// block averaging and pass-through rules or against a directed row's value.
//------------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bds_pkg::*;

   localparam logic [1:0] MODE_RSVD     = 2'd3;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         LONG_HOLD      = 300;
   localparam int         PHASE_PIXELS   = 230;
   localparam int         MAX_PRINTS     = 100;
   localparam int         NUM_DIR        = 24;

   typedef enum logic { ROW_CSR, ROW_PIX } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [PIX_W-1:0]      pix;
      logic [4:0]            reps;
      logic                  typed;
      out_item_type          want;
   } dir_row_type;

   localparam out_item_type NO_OUT = '0;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_in_pixel;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_out_pixel;
   logic                  rsp_frame_done;
   logic                  rsp_was_scaled;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_downscale_2x2_4x4_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_pixel   (req_in_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_done (rsp_frame_done),
      .rsp_was_scaled (rsp_was_scaled),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // model copy of the registers and the frame state
   logic [1:0]       cfg_mode;
   logic             cfg_alt;
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   logic [SUM_W-1:0] col_sum_mem [DEF_MAX_WIDTH/2];
   logic [SUM_W-1:0] run_row_sum;
   int unsigned      col_pos;
   int unsigned      row_pos;
   int unsigned      cur_width;
   int unsigned      cur_height;
   int unsigned      cur_factor;
   logic             scaled_prev;

   out_item_type     out_pixel_q [$];
   out_item_type     dir_want;
   bit               dir_typed = 0;
   dir_row_type      dir_tab [NUM_DIR];

   int               err_count     = 0;
   int               rsp_count     = 0;
   int               items_sent    = 0;
   int               send_idle_pct = 0;
   int               stall_pct     = 0;
   int               hold_request  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void model_reset();
      cfg_mode    = MODE_NONE;
      cfg_alt     = 1'b0;
      cfg_width   = RST_WIDTH;
      cfg_height  = RST_HEIGHT;
      run_row_sum = '0;
      col_pos     = 0;
      row_pos     = 0;
      cur_width   = 0;
      cur_height  = 0;
      cur_factor  = 0;
      scaled_prev = 1'b0;
      foreach (col_sum_mem[i]) col_sum_mem[i] = '0;
   endfunction

   function automatic void model_cfg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_SCALE_MODE:   cfg_mode   = data[1:0];
         REG_ALT_FRAMES:   cfg_alt    = data[0];
         REG_FRAME_WIDTH:  cfg_width  = data;
         REG_FRAME_HEIGHT: cfg_height = data;
         default: ;
      endcase
   endfunction

   // append one predicted transaction to the tail of the pending list
   function automatic void queue_expected(input out_item_type item);
      out_pixel_q.insert(out_pixel_q.size(), item);
   endfunction

   // Advance the model by one pixel; returns 1 when the pixel yields a result.
   function automatic bit downscale_pixel(input logic [PIX_W-1:0] pix, output out_item_type res);
      logic             sel;
      logic             last;
      logic [SUM_W-1:0] total;
      int unsigned      c;
      bit               hit;
      hit = 0;
      res = '0;
      if (col_pos == 0 && row_pos == 0) begin
         // registers are sampled on the first pixel of a frame
         sel         = (cfg_mode != MODE_NONE) && (!cfg_alt || !scaled_prev);
         cur_width   = clamp_dim(cfg_width, DEF_MAX_WIDTH);
         cur_height  = clamp_dim(cfg_height, HEIGHT_LIMIT);
         scaled_prev = sel;
         cur_factor  = 0;
         if (sel && cfg_mode == MODE_AVG2) cur_factor = 2;
         else if (sel && cfg_mode == MODE_AVG4) cur_factor = 4;
         if (cur_factor != 0 && (cur_width % cur_factor != 0 || cur_height % cur_factor != 0))
            cur_factor = 0;
         run_row_sum = '0;
         foreach (col_sum_mem[i]) col_sum_mem[i] = '0;
      end
      last = (col_pos + 1 >= cur_width) && (row_pos + 1 >= cur_height);
      if (cur_factor == 0) begin
         res = '{pix, last, 1'b0};
         hit = 1;
      end else begin
         run_row_sum = run_row_sum + pix;
         if (col_pos % cur_factor == cur_factor - 1) begin
            c     = col_pos / cur_factor;
            total = col_sum_mem[c] + run_row_sum;
            if (row_pos % cur_factor == cur_factor - 1) begin
               // truncated mean, no rounding
               res.out_pixel  = (cur_factor == 2) ? total[9:2] : total[11:4];
               res.frame_done = last;
               res.was_scaled = 1'b1;
               hit            = 1;
               col_sum_mem[c] = '0;
            end else begin
               col_sum_mem[c] = total;
            end
            run_row_sum = '0;
         end
      end
      col_pos++;
      if (col_pos >= cur_width) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= cur_height) row_pos = 0;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      if (err_count < MAX_PRINTS) $display("ERROR at %0t ns, result %0d: %s", $time, rsp_count, msg);
      err_count++;
   endtask

   // predict on input transactions, check output transactions
   always @(posedge clock) begin : monitor
      out_item_type got;
      out_item_type want;
      out_item_type res;
      bit           hit;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            hit = downscale_pixel(req_in_pixel, res);
            if (dir_typed) begin
               queue_expected(dir_want);
               dir_typed = 0;
            end else if (hit) begin
               queue_expected(res);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_pixel, rsp_frame_done, rsp_was_scaled};
            if (out_pixel_q.size() == 0) begin
               report_mismatch($sformatf("result %0h with none pending", got));
            end else begin
               want = out_pixel_q.pop_front();
               if (got.out_pixel !== want.out_pixel)
                  report_mismatch($sformatf("out_pixel %0d, predicted %0d",
                                            got.out_pixel, want.out_pixel));
               if (got.frame_done !== want.frame_done)
                  report_mismatch($sformatf("frame_done %0b, predicted %0b",
                                            got.frame_done, want.frame_done));
               if (got.was_scaled !== want.was_scaled)
                  report_mismatch($sformatf("was_scaled %0b, predicted %0b",
                                            got.was_scaled, want.was_scaled));
            end
            rsp_count++;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) quiet = 0;
         else quiet++;
      end
      $display("box_downscale_2x2_4x4_top: mismatch");
      $finish;
   end

   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            // hold off long enough for the block to back up into its input
            n            = hold_request;
            hold_request = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_in_pixel <= pix;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // drop valid, let every pending result drain, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (out_pixel_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      model_cfg_write(idx, data);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // one whole frame at the current geometry, with an optional register write
   // partway through that must only take effect on the next frame
   task automatic send_frame(input bit allow_mid_write);
      int unsigned           npix;
      int unsigned           split;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      npix  = clamp_dim(cfg_width, DEF_MAX_WIDTH) * clamp_dim(cfg_height, HEIGHT_LIMIT);
      split = (allow_mid_write && $urandom_range(0, 9) == 0) ? $urandom_range(1, npix) : npix;
      for (int unsigned p = 0; p < npix; p++) begin
         if (p == split) begin
            wait_idle();
            idx = CSR_IDX_W'($urandom_range(0, 7));
            case (idx)
               REG_SCALE_MODE:   data = CSR_DATA_W'($urandom_range(0, 3));
               REG_ALT_FRAMES:   data = CSR_DATA_W'($urandom_range(0, 1));
               REG_FRAME_WIDTH,
               REG_FRAME_HEIGHT: data = CSR_DATA_W'($urandom_range(0, 16));
               default:          data = CSR_DATA_W'($urandom_range(0, 4095));
            endcase
            csr_write(idx, data);
         end
         send_pixel(rand_pixel());
         items_sent++;
      end
   endtask

   task automatic pick_random_cfg();
      logic [1:0]       mode;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      int unsigned      r;
      int unsigned      f;
      r = $urandom_range(0, 99);
      if (r < 40) mode = MODE_AVG2;
      else if (r < 75) mode = MODE_AVG4;
      else if (r < 87) mode = MODE_NONE;
      else mode = MODE_RSVD;
      f = (mode == MODE_AVG4) ? 4 : 2;
      if ($urandom_range(0, 4) != 0) begin
         w = DIM_W'(f * $urandom_range(1, 4));
         h = DIM_W'(f * $urandom_range(1, 4));
      end else begin
         w = DIM_W'($urandom_range(0, 17));
         h = DIM_W'($urandom_range(0, 17));
      end
      wait_idle();
      csr_write(REG_SCALE_MODE, CSR_DATA_W'(mode));
      csr_write(REG_ALT_FRAMES, CSR_DATA_W'($urandom_range(0, 1)));
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      if ($urandom_range(0, 9) == 0)
         csr_write(CSR_IDX_W'($urandom_range(4, 7)), CSR_DATA_W'($urandom_range(0, 4095)));
   endtask

   task automatic run_phase(input int send_pct, input int hold_pct, input bit long_hold);
      int goal;
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      if (long_hold) begin
         // pass-through frame so results pile up during the hold-off
         wait_idle();
         csr_write(REG_SCALE_MODE, CSR_DATA_W'(MODE_NONE));
         csr_write(REG_FRAME_WIDTH, 12'd16);
         csr_write(REG_FRAME_HEIGHT, 12'd16);
         hold_request = LONG_HOLD;
         send_frame(0);
      end
      goal = items_sent + PHASE_PIXELS;
      while (items_sent < goal) begin
         pick_random_cfg();
         repeat ($urandom_range(1, 3)) send_frame(1);
      end
   endtask

   initial begin : stimulus
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_pixel = '0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      model_reset();

      dir_tab = '{
         '{ROW_CSR, REG_SCALE_MODE,   12'(MODE_AVG2), 8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_ALT_FRAMES,   12'd0,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_WIDTH,  12'd2,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_HEIGHT, 12'd2,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'hFF, 5'd3,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'hFF, 5'd1,  1'b1, '{8'hFF, 1'b1, 1'b1}},
         // sum of three truncates to zero
         '{ROW_PIX, '0,               12'd0,          8'h01, 5'd3,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'h00, 5'd1,  1'b1, '{8'h00, 1'b1, 1'b1}},
         '{ROW_CSR, REG_SCALE_MODE,   12'(MODE_NONE), 8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_WIDTH,  12'd1,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_HEIGHT, 12'd1,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'h55, 5'd1,  1'b1, '{8'h55, 1'b1, 1'b0}},
         '{ROW_PIX, '0,               12'd0,          8'hAA, 5'd1,  1'b1, '{8'hAA, 1'b1, 1'b0}},
         // reserved mode, zero size taken as 1x1, writes past the last index dropped
         '{ROW_CSR, REG_SCALE_MODE,   12'(MODE_RSVD), 8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_WIDTH,  12'd0,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_HEIGHT, 12'd0,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, 3'd6,             12'd5,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, 3'd7,             12'd5,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'h7F, 5'd1,  1'b1, '{8'h7F, 1'b1, 1'b0}},
         '{ROW_CSR, REG_SCALE_MODE,   12'(MODE_AVG4), 8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_WIDTH,  12'd4,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_CSR, REG_FRAME_HEIGHT, 12'd4,          8'h00, 5'd1,  1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'hFF, 5'd15, 1'b0, NO_OUT},
         '{ROW_PIX, '0,               12'd0,          8'hFF, 5'd1,  1'b1, '{8'hFF, 1'b1, 1'b1}}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIR; i++) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            for (int r = 1; r <= dir_tab[i].reps; r++) begin
               dir_want  = dir_tab[i].want;
               dir_typed = dir_tab[i].typed && (r == dir_tab[i].reps);
               send_pixel(dir_tab[i].pix);
            end
         end
      end

      run_phase(0, 0, 1);
      run_phase(55, 0, 0);
      run_phase(0, 55, 1);
      run_phase(20, 20, 0);

      wait_idle();
      if (err_count == 0) $display("box_downscale_2x2_4x4_top: match");
      else $display("box_downscale_2x2_4x4_top: mismatch");
      $finish;
   end

endmodule

@@ box_downscale_2x2_4x4_top.f @@
+incdir+hdl
hdl/bds_pkg.sv
hdl/bds_ctrl.sv
hdl/bds_colsum.sv
hdl/bds_outq.sv
hdl/box_downscale_2x2_4x4_top.sv
bench/tb_top.sv
